/* hdl/cbs_pkg.sv */
// ----------------------------------------------------------------------------
// cbs_pkg
// types and constants shared by the cubic bezier sampler modules
// ----------------------------------------------------------------------------
package cbs_pkg;

  localparam int TW = 17;
  localparam int CORDIC_ITERS = 30;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_WGT,
    ST_MIX,
    ST_NORM,
    ST_CORD,
    ST_EMIT
  } cbs_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic wgt_step;
    logic mix_step;
    logic norm_step;
    logic cord_step;
    logic emit;
    logic next_sample;
  } cbs_cmd_t;

  typedef struct packed {
    logic div_done;
    logic wgt_done;
    logic mix_done;
    logic norm_done;
    logic cord_done;
    logic last;
  } cbs_sts_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd843314857;
      5'd1: r = 32'd497837829;
      5'd2: r = 32'd263043837;
      5'd3: r = 32'd133525159;
      5'd4: r = 32'd67021687;
      5'd5: r = 32'd33543516;
      5'd6: r = 32'd16775851;
      5'd7: r = 32'd8388437;
      5'd8: r = 32'd4194283;
      5'd9: r = 32'd2097149;
      default: r = 32'd1 << (5'd30 - i);
    endcase
    return r;
  endfunction

endpackage

/* hdl/cbs_ctrl.sv */
// ----------------------------------------------------------------------------
// cbs_ctrl
// sequencer: divide, weights, mix, normalize, cordic, emit per sample
// ----------------------------------------------------------------------------
module cbs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [6:0]      in_point_count,
  output logic            busy,
  output cbs_pkg::cbs_cmd_t cmd,
  input  cbs_pkg::cbs_sts_t sts
);
  import cbs_pkg::*;

  cbs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_point_count != 7'd0) begin
          cmd.load = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = ST_WGT;
      end
      ST_WGT: begin
        cmd.wgt_step = 1'b1;
        if (sts.div_done && sts.wgt_done) state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix_step = 1'b1;
        if (sts.mix_done) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        cmd.norm_step = 1'b1;
        if (sts.norm_done) state_nxt = ST_CORD;
      end
      ST_CORD: begin
        cmd.cord_step = 1'b1;
        if (sts.cord_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.next_sample = 1'b1;
        state_nxt = sts.last ? ST_IDLE : ST_DIV;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* hdl/cbs_dp.sv */
// ----------------------------------------------------------------------------
// cbs_dp
// datapath: t divider, bernstein weights, mixing mac, cordic atan2
// ----------------------------------------------------------------------------
module cbs_dp #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cbs_pkg::cbs_cmd_t  cmd,
  output cbs_pkg::cbs_sts_t  sts,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_ctrl1_x,
  input  logic signed [31:0] in_ctrl1_y,
  input  logic signed [31:0] in_ctrl2_x,
  input  logic signed [31:0] in_ctrl2_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic [6:0]         in_point_count,
  input  logic signed [31:0] in_prev_x,
  input  logic signed [31:0] in_prev_y,
  output logic               out_valid,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [15:0] out_heading,
  output logic               out_last_point
);
  import cbs_pkg::*;

  localparam logic [6:0] MAXP = 7'(MAX_POINTS);

  logic signed [31:0] px_r [4];
  logic signed [31:0] py_r [4];
  logic [6:0]  n_r, idx_r;
  logic signed [31:0] lx_r, ly_r;

  // t divider, restoring, one quotient bit per cycle
  logic [22:0] rem_r;
  logic [16:0] q_r;
  logic [4:0]  dcnt_r;
  logic        div_busy_r;
  logic [23:0] rem_sh;

  // weights
  logic [2:0]  wcnt_r;
  logic [16:0] u_r;
  logic [33:0] a2_r, b2_r, c2_r;
  logic [50:0] w_raw_r [4];
  logic [30:0] w_r [4];

  // mix
  logic [3:0]  mcnt_r;
  logic signed [66:0] accx_r, accy_r;
  logic signed [32:0] sx_r, sy_r;

  // cordic
  logic signed [61:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic [4:0]  ccnt_r;
  logic        zero_r, neg_x_r, neg_y_r;
  logic signed [15:0] hd;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r[0] <= in_start_x; py_r[0] <= in_start_y;
      px_r[1] <= in_ctrl1_x; py_r[1] <= in_ctrl1_y;
      px_r[2] <= in_ctrl2_x; py_r[2] <= in_ctrl2_y;
      px_r[3] <= in_end_x;   py_r[3] <= in_end_y;
      n_r <= (in_point_count > MAXP) ? MAXP : in_point_count;
      lx_r <= in_prev_x;
      ly_r <= in_prev_y;
    end else if (cmd.emit) begin
      lx_r <= sx_r[31:0];
      ly_r <= sy_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.next_sample) begin
      idx_r <= sts.last ? 7'd0 : idx_r + 7'd1;
    end
  end

  assign sts.last = (idx_r + 7'd1 == n_r);

  assign rem_sh = {rem_r, q_r[16]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      dcnt_r <= 5'd0;
      rem_r <= {16'd0, 1'b0, idx_r[6:1]};
      q_r <= {idx_r[0], 16'd0};
    end else if (div_busy_r) begin
      if (rem_sh >= {17'd0, n_r}) begin
        rem_r <= 23'(rem_sh - {17'd0, n_r});
        q_r <= {q_r[15:0], 1'b1};
      end else begin
        rem_r <= rem_sh[22:0];
        q_r <= {q_r[15:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 5'd1;
      if (dcnt_r == 5'd16) div_busy_r <= 1'b0;
    end
  end
  // the 17-bit quotient of idx*65536/n: idx seeds top bits
  assign sts.div_done = !div_busy_r && !cmd.div_start;

  // weight sequence, up to two multiplies per step, then a rounding step
  always_ff @(posedge clk) begin
    if (!cmd.wgt_step || !sts.div_done) begin
      wcnt_r <= '0;
    end else begin
      case (wcnt_r)
        3'd0: begin
          u_r  <= 17'h10000 - q_r;
          a2_r <= 34'(q_r) * 34'(q_r);
        end
        3'd1: begin
          b2_r <= 34'(u_r) * 34'(u_r);
          c2_r <= 34'(u_r) * 34'(q_r);
        end
        3'd2: begin
          w_raw_r[0] <= 51'(b2_r) * 51'(u_r);
          w_raw_r[3] <= 51'(a2_r) * 51'(q_r);
        end
        3'd3: begin
          w_raw_r[1] <= 51'(c2_r) * 51'(u_r) * 51'd3;
          w_raw_r[2] <= 51'(c2_r) * 51'(q_r) * 51'd3;
        end
        default: begin
          for (int k = 0; k < 4; k++) begin
            w_r[k] <= 31'((w_raw_r[k] + 51'd524288) >> 20);
          end
        end
      endcase
      wcnt_r <= wcnt_r + 3'd1;
    end
  end
  assign sts.wgt_done = (wcnt_r == 3'd4);

  // mix, one weight/coordinate product per cycle per axis
  logic signed [66:0] sumx, sumy;
  assign sumx = accx_r >>> 28;
  assign sumy = accy_r >>> 28;
  always_ff @(posedge clk) begin
    if (!cmd.mix_step) begin
      mcnt_r <= '0;
      accx_r <= 67'sd134217728;
      accy_r <= 67'sd134217728;
    end else if (mcnt_r < 4'd4) begin
      accx_r <= accx_r + 67'($signed({1'b0, w_r[mcnt_r[1:0]]})) * 67'(px_r[mcnt_r[1:0]]);
      accy_r <= accy_r + 67'($signed({1'b0, w_r[mcnt_r[1:0]]})) * 67'(py_r[mcnt_r[1:0]]);
      mcnt_r <= mcnt_r + 4'd1;
    end else begin
      sx_r <= (sumx > 67'sd2147483647) ? 33'sd2147483647 :
              (sumx < -67'sd2147483648) ? -33'sd2147483648 : 33'(sumx);
      sy_r <= (sumy > 67'sd2147483647) ? 33'sd2147483647 :
              (sumy < -67'sd2147483648) ? -33'sd2147483648 : 33'(sumy);
      mcnt_r <= mcnt_r + 4'd1;
    end
  end
  assign sts.mix_done = (mcnt_r == 4'd5);

  // normalize and cordic
  logic signed [33:0] dx, dy;
  logic [33:0] ax, ay;
  assign dx = 34'(sx_r) - 34'(lx_r);
  assign dy = 34'(sy_r) - 34'(ly_r);
  assign ax = dx[33] ? 34'(-dx) : dx;
  assign ay = dy[33] ? 34'(-dy) : dy;

  logic       norm_init_r;
  logic signed [61:0] xs, ys;
  assign xs = cx_r >>> ccnt_r;
  assign ys = cy_r >>> ccnt_r;
  always_ff @(posedge clk) begin
    if (!cmd.norm_step && !cmd.cord_step) begin
      norm_init_r <= 1'b0;
      ccnt_r <= '0;
    end else if (cmd.norm_step) begin
      if (!norm_init_r) begin
        norm_init_r <= 1'b1;
        cx_r <= 62'(ax);
        cy_r <= 62'(ay);
        cz_r <= '0;
        zero_r <= (ax == 34'd0) && (ay == 34'd0);
        neg_x_r <= dx[33];
        neg_y_r <= dy[33];
      end else if (!sts.norm_done) begin
        cx_r <= cx_r <<< 1;
        cy_r <= cy_r <<< 1;
      end
    end else begin
      if (ccnt_r < 5'(CORDIC_ITERS)) begin
        if (cy_r >= 0) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + 34'(atan_q30(ccnt_r));
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - 34'(atan_q30(ccnt_r));
        end
        ccnt_r <= ccnt_r + 5'd1;
      end
    end
  end
  assign sts.norm_done = norm_init_r &&
                         (zero_r || cx_r[58] || cy_r[58]);
  assign sts.cord_done = zero_r || (ccnt_r == 5'(CORDIC_ITERS));

  logic signed [33:0] zr;
  logic signed [15:0] a;
  always_comb begin
    zr = (cz_r + 34'sd65536) >>> 17;
    if (zr < 0) a = '0;
    else if (zr > 34'(HALF_PI_Q13)) a = HALF_PI_Q13;
    else a = 16'(zr);
    if (zero_r) hd = '0;
    else if (!neg_x_r) hd = neg_y_r ? -a : a;
    else hd = neg_y_r ? a - PI_Q13 : PI_Q13 - a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_point_x <= sx_r[31:0];
      out_point_y <= sy_r[31:0];
      out_heading <= hd;
      out_last_point <= sts.last;
    end
  end

endmodule

/* hdl/cubic_bezier_sampler_with_heading_top.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_sampler_with_heading_top
// each sample runs a divide start, the divide and weights, the mix, the
// normalize shifts, the cordic iterations (none for a zero step) and the emit;
// one request at a time, busy high until the last sample is emitted;
// receiver cannot stall
// rst_n synchronous: clears the sequencer and output strobe
// ----------------------------------------------------------------------------
module cubic_bezier_sampler_with_heading_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_ctrl1_x,
  input  logic signed [31:0] in_ctrl1_y,
  input  logic signed [31:0] in_ctrl2_x,
  input  logic signed [31:0] in_ctrl2_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  input  logic [6:0]         in_point_count,
  input  logic signed [31:0] in_prev_x,
  input  logic signed [31:0] in_prev_y,
  output logic               out_valid,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [15:0] out_heading,
  output logic               out_last_point
);
  import cbs_pkg::*;

  cbs_cmd_t cmd;
  cbs_sts_t sts;

  cbs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_point_count(in_point_count),
    .busy(busy), .cmd(cmd), .sts(sts)
  );

  cbs_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_ctrl1_x(in_ctrl1_x), .in_ctrl1_y(in_ctrl1_y),
    .in_ctrl2_x(in_ctrl2_x), .in_ctrl2_y(in_ctrl2_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .in_point_count(in_point_count),
    .in_prev_x(in_prev_x), .in_prev_y(in_prev_y),
    .out_valid(out_valid), .out_point_x(out_point_x),
    .out_point_y(out_point_y), .out_heading(out_heading),
    .out_last_point(out_last_point)
  );

endmodule
